[sv/slew_limited_servo_positioner_top_defines.svh]
// Assertion macros used by the servo positioner top level.
`ifndef SLEW_LIMITED_SERVO_POSITIONER_TOP_DEFINES_SVH
`define SLEW_LIMITED_SERVO_POSITIONER_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define SLSP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition holds whenever a qualifier is set, outside reset.
`define SLSP_ASSERT_WHEN(lbl, clk, rst, qual, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (qual) |-> (cond)) else $error(msg);

`endif

[sv/slsp_pkg.sv]
// Shared types, codes and constants of the servo positioner.
`default_nettype none
package slsp_pkg;

   localparam logic [8:0] ANGLE_LIMIT = 9'd270;
   localparam logic [6:0] PERCENT_MAX = 7'd100;

   // request codes
   localparam logic [2:0] REQ_TICK  = 3'd0;
   localparam logic [2:0] REQ_GOTO  = 3'd1;
   localparam logic [2:0] REQ_STOP  = 3'd2;
   localparam logic [2:0] REQ_OPEN  = 3'd3;
   localparam logic [2:0] REQ_CLOSE = 3'd4;

   // status codes
   localparam logic [1:0] ST_CLOSED  = 2'd0;
   localparam logic [1:0] ST_CLOSING = 2'd1;
   localparam logic [1:0] ST_OPENING = 2'd2;
   localparam logic [1:0] ST_OPEN    = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_MIN_PULSE  = 2'd0;
   localparam logic [1:0] CSR_MAX_PULSE  = 2'd1;
   localparam logic [1:0] CSR_MAX_DEGREE = 2'd2;
   localparam logic [1:0] CSR_REVERSED   = 2'd3;

   // divider geometry: two quotient bits per step
   localparam int DIV_NUM_W = 24;
   localparam int DIV_DEN_W = 10;
   localparam int DIV_STEPS = DIV_NUM_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic [11:0] min_pulse;
      logic [11:0] max_pulse;
      logic [8:0]  max_degree;
      logic        reversed;
   } cfg_type;

   // classified request handed from front to back
   typedef struct packed {
      logic       pulse_valid;
      logic [8:0] pulse_angle;
      logic       drive_on;
      logic [8:0] position;
      logic [1:0] status;
      logic       notify;
   } job_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_PSTART,
      B_PWAIT,
      B_CSTART,
      B_CWAIT,
      B_DONE
   } back_state_type;

endpackage
`default_nettype wire

[sv/slsp_queue.sv]
// Two-entry job queue between the front and back parts.
`default_nettype none
module slsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  slsp_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output slsp_pkg::job_type head
);
   import slsp_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the job
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[sv/slsp_div.sv]
// Radix-4 restoring divider: two quotient bits per cycle.
`default_nettype none
module slsp_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [slsp_pkg::DIV_NUM_W-1:0]  num,
   input  logic [slsp_pkg::DIV_DEN_W-1:0]  den,
   output logic                            done,
   output logic [slsp_pkg::DIV_NUM_W-1:0]  quot
);
   import slsp_pkg::*;

   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DIV_DEN_W:0]   s1, s2;
   logic                 ge1, ge2;
   logic [DIV_DEN_W-1:0] r1, r2;

   assign done = done_ff;
   assign quot = quo_ff;

   // two dependent compare-and-subtract steps
   always_comb begin
      s1  = {rem_ff, quo_ff[DIV_NUM_W-1]};
      ge1 = (s1 >= {1'b0, den_ff});
      r1  = ge1 ? DIV_DEN_W'(s1 - {1'b0, den_ff}) : s1[DIV_DEN_W-1:0];
      s2  = {r1, quo_ff[DIV_NUM_W-2]};
      ge2 = (s2 >= {1'b0, den_ff});
      r2  = ge2 ? DIV_DEN_W'(s2 - {1'b0, den_ff}) : s2[DIV_DEN_W-1:0];
   end

   // load on start, iterate while busy
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = DIV_CNT_W'(DIV_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_NUM_W-3:0], ge1, ge2};
         rem_in = r2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule
`default_nettype wire

[sv/slsp_front.sv]
// Front part: accepts requests, updates angle state and classifies the result.
`default_nettype none
module slsp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [2:0]        req_type,
   input  logic [8:0]        angle,
   input  logic [8:0]        max_degree,
   output slsp_pkg::job_type job
);
   import slsp_pkg::*;

   logic [8:0] cur_ff, cur_in;
   logic [8:0] tgt_ff, tgt_in;
   logic       drv_ff, drv_in;

   logic [8:0] step_cur;
   logic       goto_en;
   logic [8:0] goto_ang;
   logic       pulse_valid;
   logic       notify;
   logic [1:0] status;

   // decode the request and compute the next state
   always_comb begin
      step_cur    = cur_ff;
      tgt_in      = tgt_ff;
      drv_in      = drv_ff;
      pulse_valid = 1'b0;
      notify      = 1'b0;
      goto_en     = 1'b0;
      goto_ang    = '0;
      unique case (req_type)
         REQ_TICK: begin
            if (cur_ff != tgt_ff) begin
               pulse_valid = 1'b1;
               notify      = 1'b1;
               step_cur    = (cur_ff < tgt_ff) ? cur_ff + 9'd1 : cur_ff - 9'd1;
               drv_in      = (step_cur != tgt_ff);
            end
         end
         REQ_GOTO: begin
            goto_en  = 1'b1;
            goto_ang = angle;
         end
         REQ_STOP: begin
            tgt_in = cur_ff;
            notify = 1'b1;
         end
         REQ_OPEN: begin
            goto_en  = 1'b1;
            goto_ang = max_degree;
         end
         REQ_CLOSE: begin
            goto_en  = 1'b1;
            goto_ang = '0;
         end
         default: begin
         end
      endcase
      // drop targets beyond the travel limit
      if (goto_en && (goto_ang <= ANGLE_LIMIT)) begin
         notify = (cur_ff != tgt_ff);
         tgt_in = goto_ang;
      end
      cur_in = step_cur;
   end

   // classify the resulting status
   always_comb begin
      if (cur_in == '0) begin
         status = ST_CLOSED;
      end else if (tgt_in < cur_in) begin
         status = ST_CLOSING;
      end else if (tgt_in > cur_in) begin
         status = ST_OPENING;
      end else begin
         status = ST_OPEN;
      end
   end

   always_comb begin
      job.pulse_valid = pulse_valid;
      job.pulse_angle = cur_ff;
      job.drive_on    = drv_in;
      job.position    = cur_in;
      job.status      = status;
      job.notify      = notify;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
         tgt_ff <= '0;
         drv_ff <= 1'b0;
      end else if (accept) begin
         cur_ff <= cur_in;
         tgt_ff <= tgt_in;
         drv_ff <= drv_in;
      end
   end

endmodule
`default_nettype wire

[sv/slsp_back.sv]
// Back part: scales pulse width and percent through the shared divider.
`default_nettype none
module slsp_back (
   input  logic              clock,
   input  logic              reset,
   input  slsp_pkg::cfg_type cfg,
   input  logic              q_empty,
   input  slsp_pkg::job_type q_head,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_pulse_valid,
   output logic [11:0]       rsp_pulse_us,
   output logic              rsp_drive_on,
   output logic [8:0]        rsp_position,
   output logic [1:0]        rsp_status,
   output logic [6:0]        rsp_percent,
   output logic              rsp_notify
);
   import slsp_pkg::*;

   back_state_type state_ff, state_in;

   job_type     job_ff;
   logic [20:0] prod_ff;
   logic [11:0] pulse_ff;
   logic [6:0]  pct_ff;
   logic        out_valid_ff, out_valid_in;

   logic        inverted;
   logic [11:0] diff;
   logic        deg_zero;

   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quot;
   logic [DIV_NUM_W-1:0] qv;

   logic        cap_pulse;
   logic        cap_pct;
   logic        load_out;
   logic [11:0] pulse_calc;
   logic [6:0]  pct_calc;
   logic [DIV_NUM_W-1:0] pulse_num;
   logic [DIV_NUM_W-1:0] pct_num;

   assign inverted = (cfg.max_pulse < cfg.min_pulse);
   assign diff     = inverted ? 12'd0 : cfg.max_pulse - cfg.min_pulse;
   assign deg_zero = (cfg.max_degree == '0);

   // round half up: (2*n + d) / (2*d)
   assign pulse_num = DIV_NUM_W'({prod_ff, 1'b0}) + DIV_NUM_W'(cfg.max_degree);
   assign pct_num   = DIV_NUM_W'(job_ff.position * 17'd200) + DIV_NUM_W'(cfg.max_degree);
   assign div_den   = {cfg.max_degree, 1'b0};
   assign div_num   = (state_ff == B_CSTART) ? pct_num : pulse_num;
   assign qv        = deg_zero ? '0 : div_quot;

   slsp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // fall back to min_pulse outside the pulse range and mirror when reversed
   always_comb begin
      if (inverted || (qv[DIV_NUM_W-1:12] != '0) || (qv[11:0] > diff)) begin
         pulse_calc = cfg.min_pulse;
      end else if (cfg.reversed) begin
         pulse_calc = cfg.max_pulse - qv[11:0];
      end else begin
         pulse_calc = cfg.min_pulse + qv[11:0];
      end
   end

   // saturate percent
   always_comb begin
      if (qv > DIV_NUM_W'(PERCENT_MAX)) begin
         pct_calc = PERCENT_MAX;
      end else begin
         pct_calc = qv[6:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:   if (!q_empty) state_in = B_PSTART;
         B_PSTART: state_in = B_PWAIT;
         B_PWAIT:  if (div_done) state_in = B_CSTART;
         B_CSTART: state_in = B_CWAIT;
         B_CWAIT:  if (div_done) state_in = B_DONE;
         B_DONE:   if (!out_valid_ff || rsp_pop) state_in = B_IDLE;
         default:  state_in = B_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop     = 1'b0;
      div_start = 1'b0;
      cap_pulse = 1'b0;
      cap_pct   = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         B_IDLE:   q_pop = !q_empty;
         B_PSTART: div_start = 1'b1;
         B_PWAIT:  cap_pulse = div_done;
         B_CSTART: div_start = 1'b1;
         B_CWAIT:  cap_pct = div_done;
         B_DONE:   load_out = !out_valid_ff || rsp_pop;
         default: begin
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold job, product and divider results
   always_ff @(posedge clock) begin
      if (q_pop) begin
         job_ff  <= q_head;
         prod_ff <= 21'(q_head.pulse_angle) * 21'(diff);
      end
      if (cap_pulse) begin
         // drop the width when the tick did not step
         pulse_ff <= job_ff.pulse_valid ? pulse_calc : 12'd0;
      end
      if (cap_pct) begin
         pct_ff <= pct_calc;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_pulse_valid <= job_ff.pulse_valid;
         rsp_pulse_us    <= pulse_ff;
         rsp_drive_on    <= job_ff.drive_on;
         rsp_position    <= job_ff.position;
         rsp_status      <= job_ff.status;
         rsp_percent     <= pct_ff;
         rsp_notify      <= job_ff.notify;
      end
   end

   assign rsp_empty = !out_valid_ff;

endmodule
`default_nettype wire

[sv/slew_limited_servo_positioner_top.sv]
// The back part finishes one request before it takes the next, through two 12-step
//   passes of the shared radix-4 divider (pulse scaling, then percent).
// The front takes up to two requests ahead into its job queue, plus one in work.
// Reset: synchronous, active high; clears angles, drive flag, queue and output,
//   and loads the registers with min 544, max 2400, 180 degrees, not reversed.
`default_nettype none
module slew_limited_servo_positioner_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_type,
   input  logic [8:0]  req_angle,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_pulse_valid,
   output logic [11:0] rsp_pulse_us,
   output logic        rsp_drive_on,
   output logic [8:0]  rsp_position,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_percent,
   output logic        rsp_notify,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   import slsp_pkg::*;
`include "slew_limited_servo_positioner_top_defines.svh"

   cfg_type cfg_ff, cfg_in;
   logic    accept;
   job_type front_job;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   job_type q_head;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_PULSE:  cfg_in.min_pulse  = csr_wdata;
            CSR_MAX_PULSE:  cfg_in.max_pulse  = csr_wdata;
            CSR_MAX_DEGREE: cfg_in.max_degree = csr_wdata[8:0];
            CSR_REVERSED:   cfg_in.reversed   = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_pulse  <= 12'd544;
         cfg_ff.max_pulse  <= 12'd2400;
         cfg_ff.max_degree <= 9'd180;
         cfg_ff.reversed   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   slsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_type   (req_type),
      .angle      (req_angle),
      .max_degree (cfg_ff.max_degree),
      .job        (front_job)
   );

   slsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_job),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   slsp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pulse_valid (rsp_pulse_valid),
      .rsp_pulse_us    (rsp_pulse_us),
      .rsp_drive_on    (rsp_drive_on),
      .rsp_position    (rsp_position),
      .rsp_status      (rsp_status),
      .rsp_percent     (rsp_percent),
      .rsp_notify      (rsp_notify)
   );

   `SLSP_ASSERT_WHEN(a_pos_limit, clock, reset, !rsp_empty, rsp_position <= ANGLE_LIMIT, "position beyond travel limit")
   `SLSP_ASSERT_WHEN(a_pulse_idle, clock, reset, !rsp_empty && !rsp_pulse_valid, rsp_pulse_us == 12'd0, "pulse width without a step")
   `SLSP_ASSERT_WHEN(a_pct_max, clock, reset, !rsp_empty, rsp_percent <= PERCENT_MAX, "percent above 100")
   `SLSP_ASSERT(a_no_pop_empty, clock, reset, q_pop |-> !q_empty, "job queue popped while empty")

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the slew-limited servo positioner: directed table, then random phases.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import slsp_pkg::*;

   // request codes the block must ignore
   localparam logic [2:0] REQ_RSVD5 = 3'd5;
   localparam logic [2:0] REQ_RSVD6 = 3'd6;
   localparam logic [2:0] REQ_RSVD7 = 3'd7;

   localparam int unsigned SETTLE_CYCLES = 64;
   localparam int unsigned STALL_LIMIT   = 5000;
   localparam int unsigned PHASE_COUNT   = 10;
   localparam int unsigned PHASE_ITEMS   = 112;
   localparam int unsigned HOLD_AT       = 300;
   localparam int unsigned LONG_HOLD     = 400;
   localparam int unsigned PRINT_CAP     = 40;

   typedef struct packed {
      logic        pulse_valid;
      logic [11:0] pulse_us;
      logic        drive_on;
      logic [8:0]  position;
      logic [1:0]  status;
      logic [6:0]  percent;
      logic        notify;
   } servo_report_type;

   typedef struct packed {
      logic [2:0]       rtype;
      logic [8:0]       angle;
      logic             typed;
      servo_report_type report;
   } request_row_type;

   localparam servo_report_type IDLE_REPORT = '0;
   localparam servo_report_type STOP_REPORT =
      '{1'b0, 12'd0, 1'b0, 9'd0, ST_CLOSED, 7'd0, 1'b1};
   localparam servo_report_type FIRST_STEP =
      '{1'b1, 12'd544, 1'b1, 9'd1, ST_OPENING, 7'd1, 1'b1};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [2:0]  req_type = REQ_TICK;
   logic [8:0]  req_angle = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_pulse_valid;
   logic [11:0] rsp_pulse_us;
   logic        rsp_drive_on;
   logic [8:0]  rsp_position;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_percent;
   logic        rsp_notify;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_MIN_PULSE;
   logic [11:0] csr_wdata = '0;

   // predictor state and register copy
   cfg_type     cfg = '{12'd544, 12'd2400, 9'd180, 1'b0};
   logic [8:0]  cur_deg = '0;
   logic [8:0]  tgt_deg = '0;
   logic        drive_en = 1'b0;

   servo_report_type awaited_reports[$];
   request_row_type  directed_rows [0:23];
   cfg_type          corner_cfgs [0:5];

   int unsigned fail_count = 0;
   int unsigned reports_seen = 0;
   int unsigned idle_cycles = 0;
   int unsigned rsp_wait = 0;
   bit          long_hold_done = 1'b0;
   bit          calm_mode = 1'b0;

   slew_limited_servo_positioner_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_type        (req_type),
      .req_angle       (req_angle),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pulse_valid (rsp_pulse_valid),
      .rsp_pulse_us    (rsp_pulse_us),
      .rsp_drive_on    (rsp_drive_on),
      .rsp_position    (rsp_position),
      .rsp_status      (rsp_status),
      .rsp_percent     (rsp_percent),
      .rsp_notify      (rsp_notify),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #2 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      if (p < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Pulse width for an angle: scaled with half-up rounding, mirrored, range-checked.
   function automatic logic [11:0] pulse_width(input logic [8:0] deg);
      longint lo, hi, dv, num, w;
      lo = cfg.min_pulse;
      hi = cfg.max_pulse;
      dv = cfg.max_degree;
      if (dv == 0) begin
         w = lo;
      end else begin
         num = 2 * longint'(deg) * (hi - lo) + dv;
         // floor division, since the span may be negative
         if (num >= 0) w = lo + num / (2 * dv);
         else w = lo - ((-num + 2 * dv - 1) / (2 * dv));
      end
      if (cfg.reversed) w = hi + lo - w;
      if (w < lo || w > hi) return cfg.min_pulse;
      return w[11:0];
   endfunction

   // Apply one request to the predictor state and build the report it should produce.
   function automatic servo_report_type next_servo_report(input logic [2:0] rtype,
         input logic [8:0] angle, output bit ignored);
      servo_report_type r;
      logic [8:0]       goal;
      logic [8:0]       prev;
      int unsigned      pct;
      r = '0;
      ignored = 1'b0;
      case (rtype)
         REQ_TICK: begin
            prev = cur_deg;
            if (cur_deg != tgt_deg) begin
               drive_en = 1'b1;
               r.pulse_valid = 1'b1;
               r.pulse_us = pulse_width(cur_deg);
               r.notify = 1'b1;
               if (cur_deg < tgt_deg) cur_deg = cur_deg + 9'd1;
               else cur_deg = cur_deg - 9'd1;
            end
            // arrival switches the drive off
            if (cur_deg == tgt_deg && prev != cur_deg) begin
               drive_en = 1'b0;
               r.notify = 1'b1;
            end
         end
         REQ_GOTO, REQ_OPEN, REQ_CLOSE: begin
            if (rtype == REQ_GOTO) goal = angle;
            else if (rtype == REQ_OPEN) goal = cfg.max_degree;
            else goal = '0;
            if (goal > ANGLE_LIMIT) begin
               ignored = 1'b1;
            end else begin
               // a pending move raises notify when it is retargeted
               if (cur_deg != tgt_deg) r.notify = 1'b1;
               tgt_deg = goal;
            end
         end
         REQ_STOP: begin
            tgt_deg = cur_deg;
            r.notify = 1'b1;
         end
         default: ignored = 1'b1;
      endcase
      r.drive_on = drive_en;
      r.position = cur_deg;
      if (cur_deg == '0) r.status = ST_CLOSED;
      else if (tgt_deg < cur_deg) r.status = ST_CLOSING;
      else if (tgt_deg > cur_deg) r.status = ST_OPENING;
      else r.status = ST_OPEN;
      if (cfg.max_degree == '0) begin
         pct = 0;
      end else begin
         pct = (cur_deg * 200 + cfg.max_degree) / (2 * cfg.max_degree);
         if (pct > PERCENT_MAX) pct = PERCENT_MAX;
      end
      r.percent = pct[6:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [11:0] got_v,
         input logic [11:0] want_v);
      fail_count++;
      // keep the log short when everything goes wrong
      if (fail_count <= PRINT_CAP)
         $display("MISMATCH report %0d %s: got %0d expected %0d",
                  reports_seen, what, got_v, want_v);
   endtask

   // Offer one request after a random gap (none in calm mode) and queue its expected report once accepted.
   task automatic send_request(input logic [2:0] rtype, input logic [8:0] angle,
         input bit typed, input servo_report_type typed_report, output bit ignored);
      int unsigned      gap;
      servo_report_type r;
      gap = calm_mode ? 0 : pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push  <= 1'b1;
      req_type  <= rtype;
      req_angle <= angle;
      @(posedge clock);
      while (req_full) @(posedge clock);
      r = next_servo_report(rtype, angle, ignored);
      awaited_reports.push_back(typed ? typed_report : r);
   endtask

   // Stop offering, wait for every outstanding report, then let the block settle.
   task automatic drain_servo();
      @(negedge clock);
      req_push <= 1'b0;
      while (awaited_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MIN_PULSE:  cfg.min_pulse  = val;
         CSR_MAX_PULSE:  cfg.max_pulse  = val;
         CSR_MAX_DEGREE: cfg.max_degree = val[8:0];
         CSR_REVERSED:   cfg.reversed   = val[0];
         default: ;
      endcase
   endtask

   // Random phase: a command, then mostly enough ticks to arrive, with random content.
   task automatic run_phase(input int unsigned quota);
      int unsigned done;
      int unsigned ticks;
      int unsigned p;
      int          a;
      logic [2:0]  cmd;
      logic [8:0]  ang;
      bit          ign;
      done = 0;
      while (done < quota) begin
         p = $urandom_range(0, 99);
         ang = 9'($urandom_range(0, 511));
         if (p < 55) begin
            cmd = REQ_GOTO;
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  a = int'(cur_deg) + int'($urandom_range(0, 30)) - 15;
                  if (a < 0) a = 0;
                  if (a > int'(ANGLE_LIMIT)) a = ANGLE_LIMIT;
                  ang = 9'(a);
               end
               5, 6, 7: ang = 9'($urandom_range(0, ANGLE_LIMIT));
               default: ;  // whole field, out-of-range angles included
            endcase
         end else if (p < 65) cmd = REQ_OPEN;
         else if (p < 75) cmd = REQ_CLOSE;
         else if (p < 84) cmd = REQ_STOP;
         else if (p < 90) cmd = 3'($urandom_range(REQ_RSVD5, REQ_RSVD7));
         else cmd = REQ_TICK;
         send_request(cmd, ang, 1'b0, IDLE_REPORT, ign);
         if (!ign) done++;
         ticks = (cur_deg > tgt_deg) ? cur_deg - tgt_deg : tgt_deg - cur_deg;
         if ($urandom_range(0, 3) == 0) ticks = $urandom_range(0, 4);
         else ticks = ticks + $urandom_range(0, 2);
         // cut most long travels short; let a few run to the end
         if (ticks > 48 && $urandom_range(0, 3) != 0) ticks = 48;
         repeat (ticks) begin
            send_request(REQ_TICK, 9'($urandom_range(0, 511)), 1'b0, IDLE_REPORT, ign);
            done++;
         end
      end
   endtask

   // Main sequence: reset, directed table, configured random phases, final drain.
   initial begin : stimulus
      cfg_type pc;
      bit      ign;
      logic [11:0] a, b;

      directed_rows = '{
         '{REQ_TICK,  9'd0,              1'b1, IDLE_REPORT},
         '{REQ_GOTO,  9'h1FF,            1'b1, IDLE_REPORT},
         '{REQ_GOTO,  ANGLE_LIMIT + 9'd1, 1'b1, IDLE_REPORT},
         '{REQ_RSVD5, 9'd0,              1'b1, IDLE_REPORT},
         '{REQ_RSVD6, 9'h0AA,            1'b1, IDLE_REPORT},
         '{REQ_RSVD7, 9'h1FF,            1'b1, IDLE_REPORT},
         '{REQ_STOP,  9'h155,            1'b1, STOP_REPORT},
         '{REQ_CLOSE, 9'd0,              1'b1, IDLE_REPORT},
         '{REQ_GOTO,  ANGLE_LIMIT,       1'b1, IDLE_REPORT},
         '{REQ_TICK,  9'd0,              1'b1, FIRST_STEP},
         '{REQ_TICK,  9'h1FF,            1'b0, IDLE_REPORT},
         '{REQ_GOTO,  9'd0,              1'b0, IDLE_REPORT},
         '{REQ_TICK,  9'd0,              1'b0, IDLE_REPORT},
         '{REQ_OPEN,  9'd0,              1'b0, IDLE_REPORT},
         '{REQ_TICK,  9'd0,              1'b0, IDLE_REPORT},
         '{REQ_TICK,  9'd0,              1'b0, IDLE_REPORT},
         '{REQ_STOP,  9'd0,              1'b0, IDLE_REPORT},
         '{REQ_TICK,  9'd0,              1'b0, IDLE_REPORT},
         '{REQ_CLOSE, 9'd0,              1'b0, IDLE_REPORT},
         '{REQ_TICK,  9'd0,              1'b0, IDLE_REPORT},
         '{REQ_TICK,  9'd0,              1'b0, IDLE_REPORT},
         '{REQ_TICK,  9'd0,              1'b0, IDLE_REPORT},
         '{REQ_GOTO,  9'd1,              1'b0, IDLE_REPORT},
         '{REQ_TICK,  9'd0,              1'b0, IDLE_REPORT}
      };

      // full span, inverted limits, zero scale, scale past the limit, inverted, flat
      corner_cfgs = '{
         '{12'd0,    12'd4095, 9'd270, 1'b0},
         '{12'd4095, 12'd0,    9'd1,   1'b1},
         '{12'd544,  12'd2400, 9'd0,   1'b0},
         '{12'd1000, 12'd2000, 9'h1FF, 1'b1},
         '{12'd2000, 12'd1000, 9'd90,  1'b0},
         '{12'd0,    12'd0,    9'd270, 1'b1}
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].rtype, directed_rows[i].angle,
                      directed_rows[i].typed, directed_rows[i].report, ign);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         drain_servo();
         if (ph < 6) begin
            pc = corner_cfgs[ph];
         end else begin
            a = 12'($urandom_range(0, 4095));
            b = 12'($urandom_range(0, 4095));
            // keep most random limits in order
            if ($urandom_range(0, 3) != 0 && a > b) begin
               pc.min_pulse = b;
               pc.max_pulse = a;
            end else begin
               pc.min_pulse = a;
               pc.max_pulse = b;
            end
            pc.max_degree = 9'($urandom_range(1, ANGLE_LIMIT));
            pc.reversed   = 1'($urandom_range(0, 1));
         end
         write_reg(CSR_MIN_PULSE, pc.min_pulse);
         write_reg(CSR_MAX_PULSE, pc.max_pulse);
         write_reg(CSR_MAX_DEGREE, {3'b000, pc.max_degree});
         write_reg(CSR_REVERSED, {11'd0, pc.reversed});
         @(negedge clock);
         csr_we <= 1'b0;
         calm_mode = (ph % 4 == 1);
         run_phase(PHASE_ITEMS);
      end

      drain_servo();
      if (fail_count == 0) begin
         $display("** slew_limited_servo_positioner_top: PASSED **");
      end else begin
         $display("** slew_limited_servo_positioner_top: FAILED **");
      end
      $finish;
   end

   // Drive pop: random stalls, one long hold once enough reports have come.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (rsp_wait != 0) begin
         rsp_pop <= 1'b0;
         rsp_wait--;
      end else begin
         rsp_pop <= 1'b1;
         if (!long_hold_done && reports_seen >= HOLD_AT) begin
            long_hold_done = 1'b1;
            rsp_wait = LONG_HOLD;
         end else if (!calm_mode && $urandom_range(0, 3) == 0) begin
            rsp_wait = pick_gap();
         end
      end
   end

   // Compare each accepted report with the oldest expectation.
   always @(posedge clock) begin : check_reports
      servo_report_type got;
      servo_report_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = {rsp_pulse_valid, rsp_pulse_us, rsp_drive_on, rsp_position,
                rsp_status, rsp_percent, rsp_notify};
         reports_seen++;
         if (awaited_reports.size() == 0) begin
            report_mismatch("report with no request waiting", '0, '0);
         end else begin
            want = awaited_reports.pop_front();
            if (got.pulse_valid !== want.pulse_valid)
               report_mismatch("pulse_valid", got.pulse_valid, want.pulse_valid);
            if (got.pulse_us !== want.pulse_us)
               report_mismatch("pulse_us", got.pulse_us, want.pulse_us);
            if (got.drive_on !== want.drive_on)
               report_mismatch("drive_on", got.drive_on, want.drive_on);
            if (got.position !== want.position)
               report_mismatch("position", got.position, want.position);
            if (got.status !== want.status)
               report_mismatch("status", got.status, want.status);
            if (got.percent !== want.percent)
               report_mismatch("percent", got.percent, want.percent);
            if (got.notify !== want.notify)
               report_mismatch("notify", got.notify, want.notify);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_we) begin
         idle_cycles = 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("TIMEOUT: no request or report accepted for %0d cycles", idle_cycles);
         $display("** slew_limited_servo_positioner_top: FAILED **");
         $finish;
      end else begin
         idle_cycles++;
      end
   end

endmodule
